>>> sv/rde_pkg.sv
// Shared constants and types for the postfix derivative Euler stepper.
// Token kinds, error codes and the control/status structs between
// the controller and the datapath. No dependencies.
`default_nettype none

package rde_pkg;

  // default operand stack depth
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // reset value of the step size register (about 0.01 in Q16.16)
  localparam logic [30:0] STEP_RESET = 31'd655;

  // token kinds
  localparam logic [3:0] KIND_CONST   = 4'd0;
  localparam logic [3:0] KIND_PUSH_X  = 4'd1;
  localparam logic [3:0] KIND_PUSH_Y  = 4'd2;
  localparam logic [3:0] KIND_PUSH_Z  = 4'd3;
  localparam logic [3:0] KIND_ADD     = 4'd4;
  localparam logic [3:0] KIND_SUB     = 4'd5;
  localparam logic [3:0] KIND_MUL     = 4'd6;
  localparam logic [3:0] KIND_DIV     = 4'd7;
  localparam logic [3:0] KIND_RESTART = 4'd8;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIV0  = 2'd3;

  // last axis, the one that commits the step
  localparam logic [1:0] AXIS_Z = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic tok_load;   // capture the accepted request
    logic push;       // push constant or coordinate
    logic restart;    // load start coordinates, clear stack
    logic op_under;   // operator with fewer than two operands
    logic rd_b;       // read top of stack
    logic rd_a;       // latch top, read second entry
    logic lat_a;      // latch second entry
    logic addsub;     // add or subtract into result
    logic mul;        // multiply operands
    logic norm;       // scale and saturate product into result
    logic div_zero;   // divide by zero: flag and push zero
    logic div_start;  // start the divider
    logic div_take;   // take divider quotient into result
    logic wb;         // pop two, push result
    logic fin_err;    // final token with error: keep coordinate
    logic rd_top;     // read top for the Euler update
    logic emul;       // multiply top by step size
    logic eadd;       // add increment to coordinate
    logic out_load;   // load output register and commit
  } rde_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [3:0] kind;
    logic       last;
    logic       depth_zero;
    logic       depth_lt2;
    logic       b_zero;
    logic       div_done;
    logic       err_any;
    logic       out_free;
  } rde_sts_t;

endpackage

`default_nettype wire

>>> sv/rde_tok_if.sv
// Token request channel: valid/ready handshake with one postfix token.
// Depends on nothing.
`default_nettype none

interface rde_tok_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic signed [31:0] constant;
  logic [1:0]         axis;
  logic               last_token;

  modport source (output valid, kind, constant, axis, last_token, input ready);
  modport sink   (input valid, kind, constant, axis, last_token, output ready);
endinterface

`default_nettype wire

>>> sv/rde_res_if.sv
// Result request channel: valid/ready handshake with one new coordinate.
// Depends on nothing.
`default_nettype none

interface rde_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_axis;
  logic signed [31:0] coordinate;
  logic [1:0]         error_code;
  logic               step_done;

  modport source (output valid, result_axis, coordinate, error_code, step_done,
                  input ready);
  modport sink   (input valid, result_axis, coordinate, error_code, step_done,
                  output ready);
endinterface

`default_nettype wire

>>> sv/rde_div.sv
// Iterative Q16.16 divider, one quotient bit per cycle, saturating.
// Computes (a * 65536) / b truncated toward zero; b must be nonzero.
`default_nettype none

module rde_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] dividend_i,
  input  wire logic signed [31:0] divisor_i,
  output logic                    done_o,
  output logic signed [31:0]      quotient_o
);

  localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
  localparam logic [5:0]         STEPS   = 6'd32;

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic        neg_q, ovf_q;
  logic [31:0] bmag_q, rem_q, dvd_q, quo_q;

  logic [31:0] a_mag, b_mag;
  logic        ovf;
  logic [32:0] trial, diff;
  logic        ge;
  logic        big_pos, big_neg;

  // operand magnitudes and quotient overflow check
  assign a_mag = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
  assign b_mag = divisor_i[31]  ? (~divisor_i + 32'd1)  : divisor_i;
  assign ovf   = {16'd0, a_mag} >= {b_mag, 16'd0};

  // one restoring step
  assign trial = {rem_q, dvd_q[31]};
  assign diff  = trial - {1'b0, bmag_q};
  assign ge    = trial >= {1'b0, bmag_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= ovf ? 6'd0 : STEPS;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= dividend_i[31] ^ divisor_i[31];
      ovf_q  <= ovf;
      bmag_q <= b_mag;
      rem_q  <= {16'd0, a_mag[31:16]};
      dvd_q  <= {a_mag[15:0], 16'd0};
      quo_q  <= '0;
    end else if (busy_q && (cnt_q != 6'd0)) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      dvd_q <= {dvd_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
    end
  end

  // sign and saturation
  assign big_pos = ovf_q || quo_q[31];
  assign big_neg = ovf_q || (quo_q[31] && (|quo_q[30:0]));
  assign done_o  = busy_q && (cnt_q == 6'd0);

  always_comb begin
    if (neg_q) begin
      quotient_o = big_neg ? MIN_VAL : $signed(~quo_q + 32'd1);
    end else begin
      quotient_o = big_pos ? MAX_VAL : $signed(quo_q);
    end
  end

endmodule

`default_nettype wire

>>> sv/rde_dp.sv
// Datapath: operand stack memory, coordinates, multiplier, divider,
// sticky error and the output register. Uses rde_pkg and rde_div.
`default_nettype none

module rde_dp #(
  parameter int unsigned STACK_DEPTH = rde_pkg::STACK_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rde_pkg::rde_cmd_t  cmd_i,
  output rde_pkg::rde_sts_t       sts_o,
  input  wire logic [3:0]         kind_i,
  input  wire logic signed [31:0] constant_i,
  input  wire logic [1:0]         axis_i,
  input  wire logic               last_token_i,
  input  wire logic [30:0]        step_size_i,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic signed [31:0] start_z_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [1:0]              result_axis_o,
  output logic signed [31:0]      coordinate_o,
  output logic [1:0]              error_code_o,
  output logic                    step_done_o
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic fits;
    fits = (&v[48:31]) || !(|v[48:31]);
    if (fits) begin
      sat32 = v[31:0];
    end else begin
      sat32 = v[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  endfunction

  // token registers
  logic [3:0]         kind_q;
  logic signed [31:0] const_q;
  logic [1:0]         axis_q;
  logic               last_q;

  // stack
  logic [31:0]   stk_mem [STACK_DEPTH];
  logic [DW-1:0] depth_q, depth_d;
  logic [DW-1:0] depth_m1, depth_m2;
  logic          depth_full;
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [31:0]   stk_wdata;
  logic signed [31:0] rdata_q;

  // coordinates and error
  logic signed [31:0] pos_q [3];
  logic signed [31:0] nxt_q [3];
  logic signed [31:0] pos_ax;
  logic [1:0]         sticky_q, sticky_d, flag_code;

  // arithmetic
  logic signed [31:0] a_q, b_q, r_q, coord_q, push_val;
  logic [1:0]         err_q;
  logic signed [32:0] sum;
  logic signed [31:0] mul_x, mul_y;
  logic signed [63:0] prod_d, prod_q;
  logic signed [47:0] prod_sh;
  logic signed [48:0] eul_sum;
  logic               div_done;
  logic signed [31:0] div_q;

  // output register
  logic               res_valid_q;
  logic [1:0]         res_axis_q;
  logic signed [31:0] res_coord_q;
  logic [1:0]         res_err_q;
  logic               res_done_q;

  // capture accepted token, axis 3 counts as z
  always_ff @(posedge clk_i) begin
    if (cmd_i.tok_load) begin
      kind_q  <= kind_i;
      const_q <= constant_i;
      axis_q  <= (axis_i > rde_pkg::AXIS_Z) ? rde_pkg::AXIS_Z : axis_i;
      last_q  <= last_token_i;
    end
  end

  // depth arithmetic
  assign depth_m1   = depth_q - DW'(1);
  assign depth_m2   = depth_q - DW'(2);
  assign depth_full = depth_q == DW'(STACK_DEPTH);

  // value to push
  always_comb begin
    case (kind_q)
      rde_pkg::KIND_PUSH_X: push_val = pos_q[0];
      rde_pkg::KIND_PUSH_Y: push_val = pos_q[1];
      rde_pkg::KIND_PUSH_Z: push_val = pos_q[2];
      default:              push_val = const_q;
    endcase
  end

  // stack memory ports
  assign stk_we    = (cmd_i.push && !depth_full) || cmd_i.wb;
  assign stk_waddr = cmd_i.wb ? depth_m2[AW-1:0] : depth_q[AW-1:0];
  assign stk_wdata = cmd_i.wb ? r_q : push_val;
  assign stk_re    = cmd_i.rd_b || cmd_i.rd_a || cmd_i.rd_top;
  assign stk_raddr = cmd_i.rd_a ? depth_m2[AW-1:0] : depth_m1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_re) begin
      rdata_q <= stk_mem[stk_raddr];
    end
  end

  // stack depth
  always_comb begin
    depth_d = depth_q;
    if (cmd_i.restart || cmd_i.out_load) begin
      depth_d = '0;
    end else if (cmd_i.push && !depth_full) begin
      depth_d = depth_q + DW'(1);
    end else if (cmd_i.wb) begin
      depth_d = depth_m1;
    end
  end

  // first error of the expression is kept
  always_comb begin
    flag_code = rde_pkg::ERR_NONE;
    if (cmd_i.op_under) begin
      flag_code = rde_pkg::ERR_UNDER;
    end else if (cmd_i.push && depth_full) begin
      flag_code = rde_pkg::ERR_OVER;
    end else if (cmd_i.div_zero) begin
      flag_code = rde_pkg::ERR_DIV0;
    end
  end

  always_comb begin
    sticky_d = sticky_q;
    if (cmd_i.restart || cmd_i.out_load) begin
      sticky_d = rde_pkg::ERR_NONE;
    end else if (sticky_q == rde_pkg::ERR_NONE) begin
      sticky_d = flag_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      sticky_q <= rde_pkg::ERR_NONE;
    end else begin
      depth_q  <= depth_d;
      sticky_q <= sticky_d;
    end
  end

  // operand latches
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_a) begin
      b_q <= rdata_q;
    end
    if (cmd_i.lat_a) begin
      a_q <= rdata_q;
    end
  end

  // add / subtract
  assign sum = (kind_q == rde_pkg::KIND_SUB) ? ({a_q[31], a_q} - {b_q[31], b_q})
                                             : ({a_q[31], a_q} + {b_q[31], b_q});

  // shared multiplier
  assign mul_x   = cmd_i.emul ? rdata_q : a_q;
  assign mul_y   = cmd_i.emul ? $signed({1'b0, step_size_i}) : b_q;
  assign prod_d  = mul_x * mul_y;
  assign prod_sh = prod_q[63:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul || cmd_i.emul) begin
      prod_q <= prod_d;
    end
  end

  rde_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // operator result
  always_ff @(posedge clk_i) begin
    if (cmd_i.addsub) begin
      r_q <= sat32({{16{sum[32]}}, sum});
    end else if (cmd_i.norm) begin
      r_q <= sat32({prod_sh[47], prod_sh});
    end else if (cmd_i.div_zero) begin
      r_q <= '0;
    end else if (cmd_i.div_take) begin
      r_q <= div_q;
    end
  end

  // Euler update
  assign pos_ax  = pos_q[axis_q];
  assign eul_sum = $signed({{17{pos_ax[31]}}, pos_ax}) + $signed({prod_sh[47], prod_sh});

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_err) begin
      coord_q <= pos_ax;
      err_q   <= (sticky_q != rde_pkg::ERR_NONE) ? sticky_q : rde_pkg::ERR_UNDER;
    end else if (cmd_i.eadd) begin
      coord_q <= sat32(eul_sum);
      err_q   <= rde_pkg::ERR_NONE;
    end
  end

  // committed coordinates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
    end else if (cmd_i.restart) begin
      pos_q[0] <= start_x_i;
      pos_q[1] <= start_y_i;
      pos_q[2] <= start_z_i;
    end else if (cmd_i.out_load && (axis_q == rde_pkg::AXIS_Z)) begin
      pos_q[0] <= nxt_q[0];
      pos_q[1] <= nxt_q[1];
      pos_q[2] <= coord_q;
    end
  end

  // next coordinates of the step in progress
  always_ff @(posedge clk_i) begin
    if (cmd_i.restart) begin
      nxt_q[0] <= start_x_i;
      nxt_q[1] <= start_y_i;
      nxt_q[2] <= start_z_i;
    end else if (cmd_i.out_load) begin
      nxt_q[axis_q] <= coord_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_axis_q  <= axis_q;
      res_coord_q <= coord_q;
      res_err_q   <= err_q;
      res_done_q  <= axis_q == rde_pkg::AXIS_Z;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign result_axis_o = res_axis_q;
  assign coordinate_o  = res_coord_q;
  assign error_code_o  = res_err_q;
  assign step_done_o   = res_done_q;

  // status
  assign sts_o.kind       = kind_q;
  assign sts_o.last       = last_q;
  assign sts_o.depth_zero = depth_q == '0;
  assign sts_o.depth_lt2  = depth_q < DW'(2);
  assign sts_o.b_zero     = b_q == '0;
  assign sts_o.div_done   = div_done;
  assign sts_o.err_any    = sticky_q != rde_pkg::ERR_NONE;
  assign sts_o.out_free   = !res_valid_q || res_ready_i;

endmodule

`default_nettype wire

>>> sv/rde_ctrl.sv
// Controller state machine: sequences each token through the datapath.
// Uses rde_pkg for token kinds and the command/status structs.
`default_nettype none

module rde_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tok_valid_i,
  output logic                   tok_ready_o,
  input  wire rde_pkg::rde_sts_t sts_i,
  output rde_pkg::rde_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_OPB  = 4'd2;
  localparam logic [3:0] S_OPA  = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_WB   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_EMUL = 4'd9;
  localparam logic [3:0] S_EADD = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] after_tok;

  // after a token: final check or back to idle
  assign after_tok = sts_i.last ? S_FIN : S_IDLE;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    tok_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        tok_ready_o = 1'b1;
        if (tok_valid_i) begin
          cmd_o.tok_load = 1'b1;
          state_d        = S_DEC;
        end
      end
      // decode the token kind
      S_DEC: begin
        case (sts_i.kind)
          rde_pkg::KIND_CONST,
          rde_pkg::KIND_PUSH_X,
          rde_pkg::KIND_PUSH_Y,
          rde_pkg::KIND_PUSH_Z: begin
            cmd_o.push = 1'b1;
            state_d    = after_tok;
          end
          rde_pkg::KIND_ADD,
          rde_pkg::KIND_SUB,
          rde_pkg::KIND_MUL,
          rde_pkg::KIND_DIV: begin
            if (sts_i.depth_lt2) begin
              cmd_o.op_under = 1'b1;
              state_d        = after_tok;
            end else begin
              cmd_o.rd_b = 1'b1;
              state_d    = S_OPB;
            end
          end
          rde_pkg::KIND_RESTART: begin
            cmd_o.restart = 1'b1;
            state_d       = S_IDLE;
          end
          default: begin
            state_d = after_tok;
          end
        endcase
      end
      S_OPB: begin
        cmd_o.rd_a = 1'b1;
        state_d    = S_OPA;
      end
      S_OPA: begin
        cmd_o.lat_a = 1'b1;
        state_d     = S_EXEC;
      end
      // start the operator
      S_EXEC: begin
        case (sts_i.kind)
          rde_pkg::KIND_ADD,
          rde_pkg::KIND_SUB: begin
            cmd_o.addsub = 1'b1;
            state_d      = S_WB;
          end
          rde_pkg::KIND_MUL: begin
            cmd_o.mul = 1'b1;
            state_d   = S_MUL;
          end
          rde_pkg::KIND_DIV: begin
            if (sts_i.b_zero) begin
              cmd_o.div_zero = 1'b1;
              state_d        = S_WB;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        cmd_o.norm = 1'b1;
        state_d    = S_WB;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = after_tok;
      end
      // end of expression
      S_FIN: begin
        if (sts_i.err_any || sts_i.depth_zero) begin
          cmd_o.fin_err = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = S_EMUL;
        end
      end
      S_EMUL: begin
        cmd_o.emul = 1'b1;
        state_d    = S_EADD;
      end
      S_EADD: begin
        cmd_o.eadd = 1'b1;
        state_d    = S_OUT;
      end
      // wait for room in the output register
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/rpn_derivative_euler_stepper.sv
// Top level of the postfix derivative Euler stepper: APB registers,
// controller and datapath. Uses rde_pkg, rde_tok_if, rde_res_if, rde_ctrl, rde_dp.
//
// Usage: tok_i carries one postfix token per request (kind, constant, axis,
// last_token) for the derivative expression of axis x, y or z. Tokens push a
// constant or a start-of-step coordinate, or apply + - * / in Q16.16 with
// saturation. On a final token one request leaves on res_o with the new
// coordinate (coordinate + top * dt), the first error of the expression and
// step_done, set when axis z finished and all three coordinates committed.
// A restart token loads start_x/y/z from the registers and clears the stack.
// Pushes, restarts, ignored kinds and short operators end at decode; other operators
// read two operands, then add, sub or mul, or divide in the bit-serial divider
// (32 steps), skipped on a zero divisor, cut short when the quotient saturates
// outright; a final token ends on the error or Euler path (shared 32x32 multiplier).
// One token is in work at a time; tok_i.ready is high only while idle.
// The result sits in an output register: a stalled receiver does not stop
// the next tokens, only a further result waits until the register is free.
// Reset clears stack depth, error, coordinates and the result valid, and sets
// step_size to 655; stack contents stay undefined until written.
// Registers: step_size at 0x0, start_x 0x4, start_y 0x8, start_z 0xC.
`default_nettype none

module rpn_derivative_euler_stepper #(
  parameter int unsigned STACK_DEPTH = rde_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rde_tok_if.sink          tok_i,
  rde_res_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] REG_STEP    = 2'd0;
  localparam logic [1:0] REG_START_X = 2'd1;
  localparam logic [1:0] REG_START_Y = 2'd2;
  localparam logic [1:0] REG_START_Z = 2'd3;

  logic [30:0]        step_q;
  logic signed [31:0] start_x_q, start_y_q, start_z_q;
  logic               wr_en;

  rde_pkg::rde_cmd_t cmd;
  rde_pkg::rde_sts_t sts;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= rde_pkg::STEP_RESET;
      start_x_q <= '0;
      start_y_q <= '0;
      start_z_q <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_STEP:    step_q    <= pwdata[30:0];
        REG_START_X: start_x_q <= pwdata;
        REG_START_Y: start_y_q <= pwdata;
        REG_START_Z: start_z_q <= pwdata;
        default:     step_q    <= step_q;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_STEP:    prdata = {1'b0, step_q};
      REG_START_X: prdata = start_x_q;
      REG_START_Y: prdata = start_y_q;
      REG_START_Z: prdata = start_z_q;
      default:     prdata = '0;
    endcase
  end

  rde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_i.valid),
    .tok_ready_o (tok_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rde_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (tok_i.kind),
    .constant_i    (tok_i.constant),
    .axis_i        (tok_i.axis),
    .last_token_i  (tok_i.last_token),
    .step_size_i   (step_q),
    .start_x_i     (start_x_q),
    .start_y_i     (start_y_q),
    .start_z_i     (start_z_q),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .result_axis_o (res_o.result_axis),
    .coordinate_o  (res_o.coordinate),
    .error_code_o  (res_o.error_code),
    .step_done_o   (res_o.step_done)
  );

endmodule

`default_nettype wire

>>> dv/rpn_derivative_euler_stepper_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the postfix derivative Euler stepper: random and
// directed token streams, with an in-bench Q16.16 predictor of each new coordinate.
// Depends on rde_pkg, rde_tok_if, rde_res_if and rpn_derivative_euler_stepper.

module rpn_derivative_euler_stepper_tb;

  localparam int unsigned DEPTH = rde_pkg::STACK_DEPTH_DEF;
  localparam int PHASES = 6;
  localparam int TOKENS_PER_PHASE = 265;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS = 200;

  // register indexes
  localparam logic [1:0] REG_STEP    = 2'd0;
  localparam logic [1:0] REG_START_X = 2'd1;
  localparam logic [1:0] REG_START_Y = 2'd2;
  localparam logic [1:0] REG_START_Z = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_W = 2'd3;  // out of range, folds onto z

  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
  localparam logic [3:0]         KIND_NOP = 4'd15;

  typedef struct {
    logic [3:0]         kind;
    logic signed [31:0] value;
    logic [1:0]         axis;
    logic               last;
  } token_t;

  typedef struct {
    logic [1:0]         axis;
    logic signed [31:0] coord;
    logic [1:0]         err;
    logic               done;
  } coord_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rde_tok_if tok_bus ();
  rde_res_if res_bus ();

  rpn_derivative_euler_stepper dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_i   (tok_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // pending tokens and expected coordinates
  token_t token_q[$];
  coord_t coord_due_q[$];

  int   fail_cnt = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic tok_took = 1'b0;

  // predictor state and register copies
  logic signed [31:0] stk [0:DEPTH-1];
  int unsigned        stk_depth;
  logic signed [31:0] pos [0:2];
  logic signed [31:0] next_pos [0:2];
  logic signed [31:0] start_val [0:2];
  logic [1:0]         first_err;
  logic [30:0]        dt;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic void note_err(input logic [1:0] code);
    if (first_err == rde_pkg::ERR_NONE) first_err = code;
  endfunction

  function automatic void stack_push(input logic signed [31:0] v);
    if (stk_depth >= DEPTH) begin
      note_err(rde_pkg::ERR_OVER);
      return;
    end
    stk[stk_depth] = v;
    stk_depth++;
  endfunction

  // pop a (lower) and b (top), push a op b
  function automatic void stack_apply(input logic [3:0] op);
    logic signed [31:0] a, b, r;
    if (stk_depth < 2) begin
      note_err(rde_pkg::ERR_UNDER);
      return;
    end
    b = stk[stk_depth - 1];
    a = stk[stk_depth - 2];
    case (op)
      rde_pkg::KIND_ADD: r = clamp_q16(longint'(a) + longint'(b));
      rde_pkg::KIND_SUB: r = clamp_q16(longint'(a) - longint'(b));
      rde_pkg::KIND_MUL: r = clamp_q16((longint'(a) * longint'(b)) >>> 16);
      default: begin
        if (b == 0) begin
          note_err(rde_pkg::ERR_DIV0);
          r = '0;
        end else begin
          r = clamp_q16((longint'(a) * 65536) / longint'(b));
        end
      end
    endcase
    stk_depth--;
    stk[stk_depth - 1] = r;
  endfunction

  // advance the predictor by one accepted token
  function automatic void predict_coord(input token_t t);
    coord_t     c;
    logic [1:0] ax;
    longint     inc;
    ax = (t.axis == AXIS_W) ? rde_pkg::AXIS_Z : t.axis;
    if (t.kind == rde_pkg::KIND_RESTART) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] = start_val[i];
        next_pos[i] = start_val[i];
      end
      stk_depth = 0;
      first_err = rde_pkg::ERR_NONE;
      return;
    end
    case (t.kind)
      rde_pkg::KIND_CONST: stack_push(t.value);
      rde_pkg::KIND_PUSH_X, rde_pkg::KIND_PUSH_Y, rde_pkg::KIND_PUSH_Z:
        stack_push(pos[t.kind - rde_pkg::KIND_PUSH_X]);
      rde_pkg::KIND_ADD, rde_pkg::KIND_SUB, rde_pkg::KIND_MUL, rde_pkg::KIND_DIV:
        stack_apply(t.kind);
      default: ;
    endcase
    if (!t.last) return;
    if (stk_depth == 0) note_err(rde_pkg::ERR_UNDER);
    c.axis = ax;
    c.err = first_err;
    if (first_err != rde_pkg::ERR_NONE) begin
      c.coord = pos[ax];
    end else begin
      inc = (longint'(stk[stk_depth - 1]) * longint'(dt)) >>> 16;
      c.coord = clamp_q16(longint'(pos[ax]) + inc);
    end
    next_pos[ax] = c.coord;
    c.done = (ax == rde_pkg::AXIS_Z);
    if (c.done) begin
      for (int i = 0; i < 3; i++) pos[i] = next_pos[i];
    end
    stk_depth = 0;
    first_err = rde_pkg::ERR_NONE;
    coord_due_q.push_back(c);
  endfunction

  function automatic void put_tok(input logic [3:0] kind, input logic signed [31:0] value,
                                  input logic [1:0] axis, input logic last);
    token_t t;
    t.kind = kind;
    t.value = value;
    t.axis = axis;
    t.last = last;
    token_q.push_back(t);
  endfunction

  // small values and full-range random values, with zero, one and the extremes mixed in
  function automatic logic signed [31:0] rand_q16();
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = Q_MAX;
      2: v = Q_MIN;
      3: v = Q_ONE;
      4, 5: v = $urandom;
      default: v = int'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  // apb write: setup then access, register copy follows
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_STEP) dt = val[30:0];
    else start_val[idx - REG_START_X] = val;
  endtask

  // token driver
  always @(negedge clk_i) begin : tok_driver
    token_t t;
    if (!rst_ni) begin
      tok_bus.valid <= 1'b0;
    end else if (!tok_bus.valid || tok_took) begin
      tok_took = 1'b0;
      if (token_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        t = token_q.pop_front();
        tok_bus.kind       <= t.kind;
        tok_bus.constant   <= t.value;
        tok_bus.axis       <= t.axis;
        tok_bus.last_token <= t.last;
        tok_bus.valid      <= 1'b1;
      end else begin
        tok_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (!rst_ni) res_bus.ready <= 1'b0;
    else res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: check results, then predict from accepted tokens
  always @(posedge clk_i) begin : monitor
    coord_t want;
    token_t t;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        if (coord_due_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result axis=%0d coord=%0d err=%0d done=%0d", $time,
                     res_bus.result_axis, res_bus.coordinate, res_bus.error_code,
                     res_bus.step_done);
        end else begin
          want = coord_due_q.pop_front();
          if (res_bus.result_axis !== want.axis || res_bus.coordinate !== want.coord ||
              res_bus.error_code !== want.err || res_bus.step_done !== want.done) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display({"%0t: mismatch expected axis=%0d coord=%0d err=%0d done=%0d,",
                        " got axis=%0d coord=%0d err=%0d done=%0d"},
                       $time, want.axis, want.coord, want.err, want.done,
                       res_bus.result_axis, res_bus.coordinate, res_bus.error_code,
                       res_bus.step_done);
          end
        end
      end
      if (tok_bus.valid && tok_bus.ready) begin
        t.kind = tok_bus.kind;
        t.value = tok_bus.constant;
        t.axis = tok_bus.axis;
        t.last = tok_bus.last_token;
        predict_coord(t);
        tok_took = 1'b1;
      end
    end
  end

  // run timeout
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // phases: registers, restart, directed tokens, random token stream
  initial begin : stimulus
    logic [30:0]        step_v;
    logic signed [31:0] sx, sy, sz;
    logic [1:0]         ax, axis_turn;
    int                 sel, leaves, live, n;

    tok_bus.valid = 1'b0;
    tok_bus.kind = rde_pkg::KIND_CONST;
    tok_bus.constant = '0;
    tok_bus.axis = AXIS_X;
    tok_bus.last_token = 1'b0;
    res_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    stk_depth = 0;
    first_err = rde_pkg::ERR_NONE;
    dt = rde_pkg::STEP_RESET;
    for (int i = 0; i < 3; i++) begin
      pos[i] = '0;
      next_pos[i] = '0;
      start_val[i] = '0;
    end
    axis_turn = AXIS_X;

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      // idle profile
      if (phase < 2) begin
        send_idle_pct = 23;
        recv_idle_pct = 58;
      end else if (phase < 4) begin
        send_idle_pct = 58;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // register setting for this phase
      case (phase)
        0: begin
          step_v = 31'h7fff_ffff;
          sx = Q_MAX;
          sy = Q_MIN;
          sz = '0;
        end
        1: begin
          step_v = 31'd1;
          sx = Q_MIN;
          sy = Q_MAX;
          sz = -Q_ONE;
        end
        2: begin
          step_v = rde_pkg::STEP_RESET;
          sx = rand_q16();
          sy = rand_q16();
          sz = rand_q16();
        end
        3: begin
          step_v = 31'(Q_ONE);
          sx = $urandom;
          sy = $urandom;
          sz = $urandom;
        end
        4: begin
          step_v = 31'($urandom_range(1, 32'h7fff_ffff));
          sx = rand_q16();
          sy = rand_q16();
          sz = rand_q16();
        end
        default: begin
          step_v = 31'($urandom_range(1, 32'h0004_0000));
          sx = '0;
          sy = '0;
          sz = '0;
        end
      endcase
      write_reg(REG_STEP, {1'($urandom_range(1)), step_v});
      write_reg(REG_START_X, sx);
      write_reg(REG_START_Y, sy);
      write_reg(REG_START_Z, sz);

      // restart so every coordinate is loaded before any commit
      put_tok(rde_pkg::KIND_RESTART, $urandom, 2'($urandom_range(3)),
              1'($urandom_range(1)));

      if (phase == 0) begin
        // largest constant straight to a result
        put_tok(rde_pkg::KIND_CONST, Q_MAX, AXIS_X, 1'b1);
        // coordinate pushes
        put_tok(rde_pkg::KIND_PUSH_X, $urandom, AXIS_Y, 1'b0);
        put_tok(rde_pkg::KIND_PUSH_Z, $urandom, AXIS_Y, 1'b0);
        put_tok(rde_pkg::KIND_ADD, $urandom, AXIS_Y, 1'b1);
        // saturating subtract, commits the step
        put_tok(rde_pkg::KIND_CONST, Q_MIN, rde_pkg::AXIS_Z, 1'b0);
        put_tok(rde_pkg::KIND_CONST, Q_ONE, rde_pkg::AXIS_Z, 1'b0);
        put_tok(rde_pkg::KIND_SUB, $urandom, rde_pkg::AXIS_Z, 1'b1);
        // saturating multiply
        put_tok(rde_pkg::KIND_CONST, Q_MAX, AXIS_X, 1'b0);
        put_tok(rde_pkg::KIND_CONST, Q_MAX, AXIS_X, 1'b0);
        put_tok(rde_pkg::KIND_MUL, $urandom, AXIS_X, 1'b1);
        // plain divide of a negative value
        put_tok(rde_pkg::KIND_CONST, -3 * Q_ONE, AXIS_Y, 1'b0);
        put_tok(rde_pkg::KIND_CONST, 2 * Q_ONE, AXIS_Y, 1'b0);
        put_tok(rde_pkg::KIND_DIV, $urandom, AXIS_Y, 1'b1);
        // divide by zero on the out-of-range axis
        put_tok(rde_pkg::KIND_CONST, Q_ONE, AXIS_W, 1'b0);
        put_tok(rde_pkg::KIND_CONST, '0, AXIS_W, 1'b0);
        put_tok(rde_pkg::KIND_DIV, $urandom, AXIS_W, 1'b1);
        // operator with one operand
        put_tok(rde_pkg::KIND_CONST, 32'sd5, AXIS_X, 1'b0);
        put_tok(rde_pkg::KIND_ADD, $urandom, AXIS_X, 1'b1);
        // ignored kind ends an empty expression
        put_tok(KIND_NOP, $urandom, AXIS_Y, 1'b1);
        // extra operands left at the end, only the top counts
        put_tok(rde_pkg::KIND_CONST, 32'sd7, rde_pkg::AXIS_Z, 1'b0);
        put_tok(rde_pkg::KIND_CONST, Q_ONE, rde_pkg::AXIS_Z, 1'b0);
        put_tok(rde_pkg::KIND_PUSH_Y, $urandom, rde_pkg::AXIS_Z, 1'b1);
        // underflow first, later divide by zero is not kept
        put_tok(rde_pkg::KIND_SUB, $urandom, AXIS_X, 1'b0);
        put_tok(rde_pkg::KIND_CONST, '0, AXIS_X, 1'b0);
        put_tok(rde_pkg::KIND_CONST, '0, AXIS_X, 1'b0);
        put_tok(rde_pkg::KIND_DIV, $urandom, AXIS_X, 1'b1);
      end

      // random stream, mostly well-formed expressions
      while (token_q.size() < TOKENS_PER_PHASE) begin
        if ($urandom_range(9) == 0) begin
          ax = 2'($urandom_range(3));
        end else begin
          ax = axis_turn;
          axis_turn = (axis_turn == rde_pkg::AXIS_Z) ? AXIS_X : axis_turn + 2'd1;
        end
        sel = $urandom_range(99);
        if (sel < 75) begin
          // random expression tree in postfix order
          leaves = $urandom_range(1, 6);
          live = 0;
          while (leaves > 0 || live > 1) begin
            if (live >= 2 && (leaves == 0 || $urandom_range(1) == 1)) begin
              put_tok(rde_pkg::KIND_ADD + 4'($urandom_range(3)), $urandom, ax, 1'b0);
              live--;
            end else begin
              if ($urandom_range(9) < 4)
                put_tok(rde_pkg::KIND_PUSH_X + 4'($urandom_range(2)), $urandom, ax, 1'b0);
              else
                put_tok(rde_pkg::KIND_CONST, rand_q16(), ax, 1'b0);
              leaves--;
              live++;
            end
          end
          token_q[token_q.size() - 1].last = 1'b1;
        end else if (sel < 80) begin
          // overflow the stack
          n = DEPTH + $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            put_tok(rde_pkg::KIND_CONST, rand_q16(), ax, i == n - 1);
        end else if (sel < 86) begin
          // operator short of operands
          if ($urandom_range(1) == 1)
            put_tok(rde_pkg::KIND_PUSH_X + 4'($urandom_range(2)), $urandom, ax, 1'b0);
          put_tok(rde_pkg::KIND_ADD + 4'($urandom_range(3)), $urandom, ax,
                  1'($urandom_range(1)));
        end else if (sel < 97) begin
          // any token at all
          put_tok(4'($urandom_range(15)), $urandom, 2'($urandom_range(3)),
                  $urandom_range(3) == 0);
        end else begin
          put_tok(rde_pkg::KIND_RESTART, $urandom, 2'($urandom_range(3)),
                  1'($urandom_range(1)));
        end
      end

      // drain, then let a token with no result finish
      while (token_q.size() != 0 || tok_bus.valid || coord_due_q.size() != 0)
        @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
